// ===== rtl/lbp_pyramid_sparse_features_defines.svh =====
// ----------------------------------------------------------------------------
// LBP pyramid assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LBP_PYRAMID_SPARSE_FEATURES_DEFINES_SVH
`define LBP_PYRAMID_SPARSE_FEATURES_DEFINES_SVH

// same-cycle implication
`define LPSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lpsf_pkg.sv =====
// ----------------------------------------------------------------------------
// LBP pyramid package
// Sizes, register indexes, command/status types and helpers.
// ----------------------------------------------------------------------------
package lpsf_pkg;

    localparam int MAX_WIN_W   = 8;
    localparam int MAX_WIN_H   = 8;
    localparam int MAX_LEVELS  = 4;
    localparam int STORE_DEPTH = MAX_WIN_W * MAX_WIN_H;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LOAD_W      = 7;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 14;
    localparam int FEAT_W      = 14;
    localparam int LEVEL_W     = 2;
    localparam int POS_W       = 6;
    localparam int PAT_W       = 8;
    localparam int COL_W       = $clog2(MAX_WIN_W);
    localparam int ROW_W       = $clog2(MAX_WIN_H);
    localparam int DIM_W       = 4;
    localparam int LVL_W       = 3;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int RIDX_W      = PADDR_W - 2;

    localparam logic [RIDX_W-1:0] REG_WIN_W  = 2'd0;
    localparam logic [RIDX_W-1:0] REG_WIN_H  = 2'd1;
    localparam logic [RIDX_W-1:0] REG_LEVELS = 2'd2;

    localparam logic [DIM_W-1:0] RST_WIN_W  = DIM_W'(MAX_WIN_W);
    localparam logic [DIM_W-1:0] RST_WIN_H  = DIM_W'(MAX_WIN_H);
    localparam logic [LVL_W-1:0] RST_LEVELS = LVL_W'(MAX_LEVELS);
    localparam logic [DIM_W-1:0] DIM_MIN    = 4'd3;

    typedef struct packed {
        logic              load_we;
        logic [ADDR_W-1:0] load_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              row_cap;
        logic              row_shift;
        logic              sum_issue;
        logic [ADDR_W-1:0] sum_addr;
        logic              emit;
        logic [POS_W-1:0]  pos;
        logic [LEVEL_W-1:0] level;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

    function automatic logic [DIM_W-1:0] f_clamp_dim(input logic [DIM_W-1:0] v,
                                                     input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_MIN) r = DIM_MIN;
        else if (v > hi) r = hi;
        return r;
    endfunction

    function automatic logic [LVL_W-1:0] f_clamp_lvl(input logic [LVL_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = v;
        if (v == '0) r = LVL_W'(1);
        else if (v > RST_LEVELS) r = RST_LEVELS;
        return r;
    endfunction

endpackage

// ===== rtl/lpsf_pix_if.sv =====
// ----------------------------------------------------------------------------
// LBP pyramid pixel channel
// Valid/ready channel carrying one window pixel per transaction.
// ----------------------------------------------------------------------------
interface lpsf_pix_if import lpsf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== rtl/lpsf_feat_if.sv =====
// ----------------------------------------------------------------------------
// LBP pyramid feature channel
// Valid/ready channel carrying one feature per transaction.
// ----------------------------------------------------------------------------
interface lpsf_feat_if import lpsf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FEAT_W-1:0]  feature_index;
    logic [LEVEL_W-1:0] level;
    logic               last;

    modport source (output valid, output feature_index, output level, output last,
                    input ready);
    modport sink   (input valid, input feature_index, input level, input last,
                    output ready);
endinterface

// ===== rtl/lpsf_datapath.sv =====
// ----------------------------------------------------------------------------
// LBP pyramid datapath
// Pixel store, 3x3 window, pattern compare, level sums and result register.
// ----------------------------------------------------------------------------
module lpsf_datapath import lpsf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_out_ready,
    output t_stat              o_stat,
    output logic               o_out_valid,
    output logic [FEAT_W-1:0]  o_feature_index,
    output logic [LEVEL_W-1:0] o_level,
    output logic               o_last
);

    logic [SUM_W-1:0]   r_mem [STORE_DEPTH];
    logic [SUM_W-1:0]   r_rd_a;
    logic [SUM_W-1:0]   r_rd_b;
    logic [SUM_W-1:0]   r_new_l;
    logic [SUM_W-1:0]   r_new_m;
    logic [SUM_W-1:0]   r_win [3][3];
    logic               r_sum_pend;
    logic [ADDR_W-1:0]  r_sum_addr;
    logic               r_out_valid;
    logic [FEAT_W-1:0]  r_feat;
    logic [LEVEL_W-1:0] r_level;
    logic               r_last;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [SUM_W-1:0]   wr_data;
    logic [PAT_W-1:0]   pattern;
    logic [SUM_W-1:0]   center;

    always_comb begin
        wr_en   = i_cmd.load_we | r_sum_pend;
        wr_addr = r_sum_pend ? r_sum_addr : i_cmd.load_addr;
        wr_data = r_sum_pend ? SUM_W'(r_rd_a + r_rd_b) : SUM_W'(i_pixel);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem[i_cmd.rd_addr_a];
            r_rd_b <= r_mem[i_cmd.rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_addr <= i_cmd.sum_addr;
        if (i_cmd.row_cap) begin
            r_new_l <= r_rd_a;
            r_new_m <= r_rd_b;
        end
        if (i_cmd.row_shift) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2][0] <= r_new_l;
            r_win[2][1] <= r_new_m;
            r_win[2][2] <= r_rd_a;
        end
    end

    always_comb begin
        center     = r_win[1][1];
        pattern[0] = r_win[0][0] < center;
        pattern[1] = r_win[0][1] < center;
        pattern[2] = r_win[0][2] < center;
        pattern[3] = r_win[1][0] < center;
        pattern[4] = r_win[1][2] < center;
        pattern[5] = r_win[2][0] < center;
        pattern[6] = r_win[2][1] < center;
        pattern[7] = r_win[2][2] < center;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum_pend <= i_cmd.sum_issue;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_feat  <= {i_cmd.pos, pattern};
            r_level <= i_cmd.level;
            r_last  <= i_cmd.last;
        end
    end

    assign o_stat.out_full = r_out_valid & ~i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_feature_index = r_feat;
    assign o_level         = r_level;
    assign o_last          = r_last;

endmodule

// ===== rtl/lpsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// LBP pyramid controller
// Sequences pixel load, pattern scan, and 2x2 level reduction passes.
// ----------------------------------------------------------------------------
`include "lbp_pyramid_sparse_features_defines.svh"

module lpsf_ctrl import lpsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DIM_W-1:0] i_win_w,
    input  logic [DIM_W-1:0] i_win_h,
    input  logic [LVL_W-1:0] i_levels,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    localparam int MUL_W = COL_W + DIM_W + 1;

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_RD0   = 9'b000000010,
        S_RD1   = 9'b000000100,
        S_RD2   = 9'b000001000,
        S_EMIT  = 9'b000010000,
        S_HSUM  = 9'b000100000,
        S_HWAIT = 9'b001000000,
        S_VSUM  = 9'b010000000,
        S_VWAIT = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [LOAD_W-1:0]  r_lc, n_lc;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LEVEL_W-1:0] r_lvl, n_lvl;
    logic [DIM_W-1:0]   r_w, n_w;
    logic [DIM_W-1:0]   r_h, n_h;
    logic [COL_W-1:0]   r_x, n_x;
    logic [ROW_W-1:0]   r_r, n_r;

    logic [DIM_W-1:0]   cw, ch;
    logic [LVL_W-1:0]   cl;
    logic [LOAD_W-1:0]  total;
    logic [LOAD_W-1:0]  lc_inc;
    logic [DIM_W-1:0]   w_n, h_n, h_e;
    logic               next_ok;
    logic               end_col, end_row;
    logic               hs_end_y, vs_end_y, s_end_x;
    logic [COL_W-1:0]   x2;
    logic [ROW_W-1:0]   y2;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [COL_W-1:0] c,
                                                 input logic [ROW_W-1:0] r,
                                                 input logic [DIM_W-1:0] h);
        logic [MUL_W-1:0] a;
        a = MUL_W'(c) * MUL_W'(h) + MUL_W'(r);
        return a[ADDR_W-1:0];
    endfunction

    always_comb begin
        cw       = f_clamp_dim(i_win_w, RST_WIN_W);
        ch       = f_clamp_dim(i_win_h, RST_WIN_H);
        cl       = f_clamp_lvl(i_levels);
        total    = LOAD_W'(cw) * LOAD_W'(ch);
        lc_inc   = r_lc + LOAD_W'(1);
        w_n      = r_w >> 1;
        h_n      = r_h >> 1;
        h_e      = {r_h[DIM_W-1:1], 1'b0};
        next_ok  = (LVL_W'(r_lvl) + LVL_W'(1) < cl) && (w_n >= DIM_MIN) && (h_n >= DIM_MIN);
        end_col  = DIM_W'(r_x) == r_w - DIM_W'(2);
        end_row  = DIM_W'(r_r) == r_h - DIM_W'(1);
        hs_end_y = DIM_W'(r_r) + DIM_W'(1) == h_e;
        vs_end_y = DIM_W'(r_r) + DIM_W'(1) == h_n;
        s_end_x  = DIM_W'(r_x) + DIM_W'(1) == w_n;
        x2       = {r_x[COL_W-2:0], 1'b0};
        y2       = {r_r[ROW_W-2:0], 1'b0};
    end

    always_comb begin
        n_state    = r_state;
        n_lc       = r_lc;
        n_pos      = r_pos;
        n_lvl      = r_lvl;
        n_w        = r_w;
        n_h        = r_h;
        n_x        = r_x;
        n_r        = r_r;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.pos   = r_pos;
        o_cmd.level = r_lvl;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_we   = r_lc < LOAD_W'(STORE_DEPTH);
                    o_cmd.load_addr = r_lc[ADDR_W-1:0];
                    n_lc            = lc_inc;
                    if (lc_inc >= total) begin
                        n_state = S_RD0;
                        n_lvl   = '0;
                        n_w     = cw;
                        n_h     = ch;
                        n_x     = COL_W'(1);
                        n_r     = '0;
                    end
                end
            end
            S_RD0: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_addr_a = f_addr(r_x - COL_W'(1), r_r, ch);
                o_cmd.rd_addr_b = f_addr(r_x, r_r, ch);
                n_state         = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_addr_a = f_addr(r_x + COL_W'(1), r_r, ch);
                o_cmd.row_cap   = 1'b1;
                n_state         = S_RD2;
            end
            S_RD2: begin
                o_cmd.row_shift = 1'b1;
                if (r_r >= ROW_W'(2)) begin
                    n_state = S_EMIT;
                end else begin
                    n_r     = r_r + ROW_W'(1);
                    n_state = S_RD0;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_full) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = end_col && end_row && !next_ok;
                    n_pos      = r_pos + POS_W'(1);
                    if (end_row && end_col) begin
                        n_x = '0;
                        n_r = '0;
                        if (next_ok) begin
                            n_state = S_HSUM;
                        end else begin
                            n_state = S_LOAD;
                            n_lc    = '0;
                            n_pos   = '0;
                        end
                    end else if (end_row) begin
                        n_x     = r_x + COL_W'(1);
                        n_r     = '0;
                        n_state = S_RD0;
                    end else begin
                        n_r     = r_r + ROW_W'(1);
                        n_state = S_RD0;
                    end
                end
            end
            S_HSUM: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.sum_issue = 1'b1;
                o_cmd.rd_addr_a = f_addr(x2, r_r, ch);
                o_cmd.rd_addr_b = f_addr(x2 + COL_W'(1), r_r, ch);
                o_cmd.sum_addr  = f_addr(r_x, r_r, ch);
                if (hs_end_y) begin
                    n_r = '0;
                    if (s_end_x) begin
                        n_x     = '0;
                        n_state = S_HWAIT;
                    end else begin
                        n_x = r_x + COL_W'(1);
                    end
                end else begin
                    n_r = r_r + ROW_W'(1);
                end
            end
            S_HWAIT: begin
                n_state = S_VSUM;
            end
            S_VSUM: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.sum_issue = 1'b1;
                o_cmd.rd_addr_a = f_addr(r_x, y2, ch);
                o_cmd.rd_addr_b = f_addr(r_x, y2 + ROW_W'(1), ch);
                o_cmd.sum_addr  = f_addr(r_x, r_r, ch);
                if (vs_end_y) begin
                    n_r = '0;
                    if (s_end_x) begin
                        n_x     = '0;
                        n_state = S_VWAIT;
                    end else begin
                        n_x = r_x + COL_W'(1);
                    end
                end else begin
                    n_r = r_r + ROW_W'(1);
                end
            end
            S_VWAIT: begin
                n_lvl   = r_lvl + LEVEL_W'(1);
                n_w     = w_n;
                n_h     = h_n;
                n_x     = COL_W'(1);
                n_r     = '0;
                n_state = S_RD0;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_lc    <= '0;
            r_pos   <= '0;
            r_lvl   <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_x     <= '0;
            r_r     <= '0;
        end else begin
            r_state <= n_state;
            r_lc    <= n_lc;
            r_pos   <= n_pos;
            r_lvl   <= n_lvl;
            r_w     <= n_w;
            r_h     <= n_h;
            r_x     <= n_x;
            r_r     <= n_r;
        end
    end

    `LPSF_ASSERT_IMP(a_emit_slot_free, o_cmd.emit, !i_stat.out_full, "emit into a full result slot")
    `LPSF_ASSERT_NXT(a_last_to_load, o_cmd.emit && o_cmd.last, r_state == S_LOAD, "no return to load after last")
    `LPSF_ASSERT_IMP(a_load_pos_clear, r_state == S_LOAD, r_pos == '0, "position count not cleared in load")
    `LPSF_ASSERT_IMP(a_load_no_sum, o_cmd.load_we, !o_cmd.sum_issue, "load write overlaps level sum")

endmodule

// ===== rtl/lbp_pyramid_sparse_features.sv =====
// ----------------------------------------------------------------------------
// LBP pyramid sparse features
// 3x3 local binary patterns over a pixel window and its 2x2-summed levels.
// ----------------------------------------------------------------------------
//  port       dir  transaction
//  i_pix      in   one 8-bit pixel, column-major, rows fastest
//  o_feat     out  feature_index, level, last
//  apb        in   window_width @0x0, window_height @0x4, pyramid_levels @0x8
//
//  Load accepts one pixel per cycle; no pixel is taken while a window is evaluated.
//  Per level of size w x h, the pattern scan is paced by the three store reads
//  per row; a horizontal then a vertical sum pass then builds the next level.
//  A stalled result holds the scan; synchronous active-low reset, no store clear.
// ----------------------------------------------------------------------------
module lbp_pyramid_sparse_features import lpsf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lpsf_pix_if.sink            i_pix,
    lpsf_feat_if.source         o_feat,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [DIM_W-1:0] r_win_w;
    logic [DIM_W-1:0] r_win_h;
    logic [LVL_W-1:0] r_levels;
    logic [RIDX_W-1:0] reg_idx;
    logic              cfg_wr;
    t_cmd              cmd;
    t_stat             stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w  <= RST_WIN_W;
            r_win_h  <= RST_WIN_H;
            r_levels <= RST_LEVELS;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WIN_W:  r_win_w  <= pwdata[DIM_W-1:0];
                REG_WIN_H:  r_win_h  <= pwdata[DIM_W-1:0];
                REG_LEVELS: r_levels <= pwdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIN_W:  prdata = PDATA_W'(r_win_w);
            REG_WIN_H:  prdata = PDATA_W'(r_win_h);
            REG_LEVELS: prdata = PDATA_W'(r_levels);
            default:    prdata = '0;
        endcase
    end

    lpsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_win_w    (r_win_w),
        .i_win_h    (r_win_h),
        .i_levels   (r_levels),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lpsf_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_pixel         (i_pix.pixel),
        .i_out_ready     (o_feat.ready),
        .o_stat          (stat),
        .o_out_valid     (o_feat.valid),
        .o_feature_index (o_feat.feature_index),
        .o_level         (o_feat.level),
        .o_last          (o_feat.last)
    );

endmodule
